// ===== sv/ajd_pkg.sv =====
// ----------------------------------------------------------------------------
// ajd_pkg
// shared types, constants and coefficient table of the jump detector
// ----------------------------------------------------------------------------
package ajd_pkg;

  localparam int WIN_N      = 64;
  localparam int WIN_AW     = $clog2(WIN_N);
  localparam int SUM_W      = 20 + WIN_AW;
  localparam int SQ_W       = 40 + WIN_AW;
  localparam int PROD_W     = 2 * SUM_W;
  localparam int WARMUP_N   = 8;
  localparam int TOL_FIXED  = 2;
  localparam int TOL_RATIO  = 26;
  localparam int FIR_TAPS   = 7;
  localparam int CNT_W      = 7;

  localparam logic [19:0] ONE_G_Q4   = 20'd65536;
  localparam logic [15:0] HALL_MAX   = 16'hFFFF;
  localparam logic [7:0]  DIP_RUN_MAX = 8'hFF;

  localparam logic [1:0] CMD_SAMPLE  = 2'd0;
  localparam logic [1:0] CMD_CLEAR   = 2'd1;
  localparam logic [1:0] CMD_RESTART = 2'd2;

  localparam logic [2:0] REG_PEAK_THR  = 3'd0;
  localparam logic [2:0] REG_RESET_HYS = 3'd1;
  localparam logic [2:0] REG_DIP_DEPTH = 3'd2;
  localparam logic [2:0] REG_DIP_MIN   = 3'd3;
  localparam logic [2:0] REG_MIN_INT   = 3'd4;
  localparam logic [2:0] REG_VAR_MAX   = 3'd5;
  localparam logic [2:0] REG_BASE_MIN  = 3'd6;
  localparam logic [2:0] REG_BASE_MAX  = 3'd7;

  typedef enum logic [3:0] {
    S_IDLE, S_CMD, S_SQ, S_ROOT, S_TAP, S_FILT, S_CAL, S_SUM,
    S_CHK1, S_CHK2, S_DET, S_OUT
  } ctrl_state_e;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_ACT, OP_SQ, OP_ROOT, OP_TAP, OP_FILT, OP_CAL,
    OP_SUM, OP_CHK1, OP_CHK2, OP_DET, OP_OUT
  } dp_op_e;

  typedef struct packed {
    dp_op_e             op;
    logic [CNT_W-1:0]   cnt;
  } dp_cmd_t;

  typedef struct packed {
    logic locked;
    logic cal_full;
    logic out_free;
  } dp_stat_t;

  typedef struct packed {
    logic [19:0] peak_thr;
    logic [19:0] reset_hys;
    logic [19:0] dip_depth;
    logic [7:0]  dip_min;
    logic [15:0] min_int;
    logic [31:0] var_max;
    logic [19:0] base_min;
    logic [19:0] base_max;
  } cfg_t;

  function automatic logic [13:0] fir_coef(input logic [2:0] k);
    logic [13:0] c;
    unique case (k)
      3'd0, 3'd6: c = 14'd1262;
      3'd1, 3'd5: c = 14'd3588;
      3'd2, 3'd4: c = 14'd6619;
      3'd3:       c = 14'd8192;
      default:    c = 14'd0;
    endcase
    return c;
  endfunction

endpackage

// ===== sv/ajd_ctrl.sv =====
// ----------------------------------------------------------------------------
// ajd_ctrl
// sequencer that steps the datapath through one item
// ----------------------------------------------------------------------------
module ajd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [1:0]        in_cmd_i,
  output logic              in_ready_o,
  input  ajd_pkg::dp_stat_t stat_i,
  output ajd_pkg::dp_cmd_t  cmd_o
);

  ajd_pkg::ctrl_state_e            state_q, state_d;
  logic [ajd_pkg::CNT_W-1:0]       cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ajd_pkg::S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q + 1'b1;
    unique case (state_q)
      ajd_pkg::S_IDLE: begin
        cnt_d = '0;
        if (in_valid_i) begin
          state_d = (in_cmd_i == ajd_pkg::CMD_SAMPLE) ? ajd_pkg::S_SQ : ajd_pkg::S_CMD;
        end
      end
      ajd_pkg::S_CMD: state_d = ajd_pkg::S_OUT;
      ajd_pkg::S_SQ: begin
        if (cnt_q == ajd_pkg::CNT_W'(2)) begin
          state_d = ajd_pkg::S_ROOT;
          cnt_d   = '0;
        end
      end
      ajd_pkg::S_ROOT: begin
        if (cnt_q == ajd_pkg::CNT_W'(15)) begin
          state_d = ajd_pkg::S_TAP;
          cnt_d   = '0;
        end
      end
      ajd_pkg::S_TAP: begin
        if (cnt_q == ajd_pkg::CNT_W'(ajd_pkg::FIR_TAPS - 1)) begin
          state_d = ajd_pkg::S_FILT;
        end
      end
      ajd_pkg::S_FILT: state_d = stat_i.locked ? ajd_pkg::S_DET : ajd_pkg::S_CAL;
      ajd_pkg::S_CAL: begin
        cnt_d   = '0;
        state_d = stat_i.cal_full ? ajd_pkg::S_SUM : ajd_pkg::S_OUT;
      end
      ajd_pkg::S_SUM: begin
        if (cnt_q == ajd_pkg::CNT_W'(ajd_pkg::WIN_N + 1)) begin
          state_d = ajd_pkg::S_CHK1;
        end
      end
      ajd_pkg::S_CHK1: state_d = ajd_pkg::S_CHK2;
      ajd_pkg::S_CHK2: state_d = ajd_pkg::S_OUT;
      ajd_pkg::S_DET:  state_d = ajd_pkg::S_OUT;
      ajd_pkg::S_OUT: begin
        if (stat_i.out_free) begin
          state_d = ajd_pkg::S_IDLE;
        end
      end
      default: state_d = ajd_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.cnt  = cnt_q;
    cmd_o.op   = ajd_pkg::OP_NONE;
    in_ready_o = 1'b0;
    unique case (state_q)
      ajd_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = ajd_pkg::OP_LOAD;
        end
      end
      ajd_pkg::S_CMD:  cmd_o.op = ajd_pkg::OP_ACT;
      ajd_pkg::S_SQ:   cmd_o.op = ajd_pkg::OP_SQ;
      ajd_pkg::S_ROOT: cmd_o.op = ajd_pkg::OP_ROOT;
      ajd_pkg::S_TAP:  cmd_o.op = ajd_pkg::OP_TAP;
      ajd_pkg::S_FILT: cmd_o.op = ajd_pkg::OP_FILT;
      ajd_pkg::S_CAL:  cmd_o.op = ajd_pkg::OP_CAL;
      ajd_pkg::S_SUM:  cmd_o.op = ajd_pkg::OP_SUM;
      ajd_pkg::S_CHK1: cmd_o.op = ajd_pkg::OP_CHK1;
      ajd_pkg::S_CHK2: cmd_o.op = ajd_pkg::OP_CHK2;
      ajd_pkg::S_DET:  cmd_o.op = ajd_pkg::OP_DET;
      ajd_pkg::S_OUT: begin
        if (stat_i.out_free) begin
          cmd_o.op = ajd_pkg::OP_OUT;
        end
      end
      default: cmd_o.op = ajd_pkg::OP_NONE;
    endcase
  end

endmodule

// ===== sv/ajd_dpath.sv =====
// ----------------------------------------------------------------------------
// ajd_dpath
// magnitude, filter, calibration window, jump detection and output register
// ----------------------------------------------------------------------------
module ajd_dpath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ajd_pkg::dp_cmd_t  cmd_i,
  output ajd_pkg::dp_stat_t stat_o,
  input  ajd_pkg::cfg_t     cfg_i,
  input  logic [1:0]        in_cmd_i,
  input  logic [95:0]       in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [55:0]       out_data_o
);

  localparam int AW = ajd_pkg::WIN_AW;

  // input capture
  logic [1:0]  icmd_q;
  logic [15:0] ax_q, ay_q, az_q, hall_q;
  logic [31:0] now_q;
  // magnitude and filter
  logic [31:0] ssq_q, rem_q, res_q, acc_q;
  logic [15:0] hist_q [ajd_pkg::FIR_TAPS-1];
  logic [19:0] filt_q;
  // calibration
  logic [7:0]                    warm_q;
  logic [AW:0]                   fill_q;
  logic [AW-1:0]                 base_ptr_q;
  logic [19:0]                   win_mem [ajd_pkg::WIN_N];
  logic [19:0]                   rd_q, x_q;
  logic [39:0]                   prod_q;
  logic                          v1_q, v2_q;
  logic [ajd_pkg::SUM_W-1:0]     sum_q;
  logic [ajd_pkg::SQ_W-1:0]      sq_q;
  logic [ajd_pkg::PROD_W-1:0]    sum2_q;
  // detection
  logic        locked_q;
  logic [19:0] baseline_q, prev_q;
  logic [20:0] peak_q;
  logic        rise_q, rearm_q, conf_q, hit_q;
  logic [7:0]  run_q;
  logic [31:0] last_q;
  logic [15:0] jt_q;
  // output register
  logic        ovalid_q;
  logic [55:0] odata_q;

  logic [15:0] sel_axis, tap_mag;
  logic [31:0] sq_term, bit_w, try_w;
  logic [4:0]  shamt;
  logic [29:0] tap_prod;
  logic [32:0] rnd;
  logic [AW-1:0] rd_addr, wr_addr;
  logic        issue;
  logic [ajd_pkg::PROD_W-1:0] nsq, rhs, lhs;
  logic        win_ok;
  logic [20:0] reset_lvl, dip_sum;
  logic        is_dip;
  logic [7:0]  run_n;
  logic        conf_n, rise_n, rearm_n, hit_n;
  logic [15:0] jt_n;
  logic [31:0] last_n, since;
  logic [24:0] ratio_p;
  logic [15:0] tol, cap;
  logic [16:0] lim;

  function automatic logic [15:0] abs16(input logic [15:0] v);
    return v[15] ? 16'(-v) : v;
  endfunction

  assign stat_o.locked   = locked_q;
  assign stat_o.cal_full = (warm_q >= 8'(ajd_pkg::WARMUP_N))
                         && (fill_q == (AW+1)'(ajd_pkg::WIN_N - 1));
  assign stat_o.out_free = !ovalid_q || out_ready_i;
  assign out_valid_o     = ovalid_q;
  assign out_data_o      = odata_q;

  // square of one axis per step
  always_comb begin
    case (cmd_i.cnt[1:0])
      2'd0:    sel_axis = ax_q;
      2'd1:    sel_axis = ay_q;
      default: sel_axis = az_q;
    endcase
    sq_term = sel_axis * sel_axis;
  end

  // one root digit per step
  assign shamt = 5'd30 - {cmd_i.cnt[3:0], 1'b0};
  assign bit_w = 32'd1 << shamt;
  assign try_w = res_q + bit_w;

  // one filter tap per step
  always_comb begin
    if (cmd_i.cnt[2:0] == 3'd0 || cmd_i.cnt[2:0] == 3'd7) begin
      tap_mag = res_q[15:0];
    end else begin
      tap_mag = hist_q[cmd_i.cnt[2:0] - 3'd1];
    end
    tap_prod = tap_mag * ajd_pkg::fir_coef(cmd_i.cnt[2:0]);
  end
  assign rnd = {1'b0, acc_q} + 33'd1024;

  // window addressing, circular so that dropping the older half is a pointer move
  assign wr_addr = base_ptr_q + fill_q[AW-1:0];
  assign rd_addr = base_ptr_q + cmd_i.cnt[AW-1:0];
  assign issue   = (cmd_i.op == ajd_pkg::OP_SUM) && (cmd_i.cnt < 7'(ajd_pkg::WIN_N));

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == ajd_pkg::OP_CAL && warm_q >= 8'(ajd_pkg::WARMUP_N)
        && fill_q < (AW+1)'(ajd_pkg::WIN_N)) begin
      win_mem[wr_addr] <= filt_q;
    end
    rd_q <= win_mem[rd_addr];
  end

  // window check: N*sum(x^2) - sum^2 against var_max*N^2, mean within limits
  assign nsq    = ajd_pkg::PROD_W'(sq_q) << AW;
  assign rhs    = ajd_pkg::PROD_W'(cfg_i.var_max) << (2 * AW);
  assign lhs    = nsq - sum2_q;
  assign win_ok = (lhs <= rhs)
               && (sum_q >= (ajd_pkg::SUM_W'(cfg_i.base_min) << AW))
               && (sum_q <= (ajd_pkg::SUM_W'(cfg_i.base_max) << AW));

  // detection of one sample
  always_comb begin
    reset_lvl = {1'b0, baseline_q} + {1'b0, cfg_i.reset_hys};
    dip_sum   = {1'b0, filt_q} + {1'b0, cfg_i.dip_depth};
    is_dip    = dip_sum < {1'b0, baseline_q};
    since     = now_q - last_q;
    run_n     = '0;
    conf_n    = conf_q;
    rise_n    = rise_q;
    rearm_n   = rearm_q;
    jt_n      = jt_q;
    last_n    = last_q;
    hit_n     = 1'b0;
    if (is_dip) begin
      run_n = (run_q == ajd_pkg::DIP_RUN_MAX) ? run_q : run_q + 8'd1;
      if (run_n >= cfg_i.dip_min) conf_n = 1'b1;
    end
    if (rearm_q) begin
      if ({1'b0, filt_q} < reset_lvl) rearm_n = 1'b0;
    end else if (prev_q < filt_q) begin
      rise_n = 1'b1;
    end else if (rise_q && prev_q > filt_q) begin
      if (conf_n && {1'b0, prev_q} > peak_q && since >= {16'd0, cfg_i.min_int}) begin
        jt_n    = jt_q + 16'd1;
        last_n  = now_q;
        rearm_n = 1'b1;
        conf_n  = 1'b0;
        run_n   = '0;
        hit_n   = 1'b1;
      end
      rise_n = 1'b0;
    end
  end

  // hall cap
  always_comb begin
    ratio_p = jt_q * 9'(ajd_pkg::TOL_RATIO);
    tol     = (ratio_p[23:8] > 16'(ajd_pkg::TOL_FIXED)) ? ratio_p[23:8]
                                                        : 16'(ajd_pkg::TOL_FIXED);
    lim     = {1'b0, jt_q} + {1'b0, tol};
    if (lim > {1'b0, ajd_pkg::HALL_MAX}) lim = {1'b0, ajd_pkg::HALL_MAX};
    if (!locked_q || {1'b0, hall_q} <= lim) cap = hall_q;
    else cap = lim[15:0];
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      ajd_pkg::OP_LOAD: begin
        icmd_q <= in_cmd_i;
        ax_q   <= abs16(in_data_i[15:0]);
        ay_q   <= abs16(in_data_i[31:16]);
        az_q   <= abs16(in_data_i[47:32]);
        now_q  <= in_data_i[79:48];
        hall_q <= in_data_i[95:80];
        filt_q <= '0;
        hit_q  <= 1'b0;
      end
      ajd_pkg::OP_SQ: begin
        ssq_q <= ((cmd_i.cnt[1:0] == 2'd0) ? 32'd0 : ssq_q) + sq_term;
        rem_q <= ((cmd_i.cnt[1:0] == 2'd0) ? 32'd0 : ssq_q) + sq_term;
        res_q <= '0;
      end
      ajd_pkg::OP_ROOT: begin
        if (rem_q >= try_w) begin
          rem_q <= rem_q - try_w;
          res_q <= (res_q >> 1) + bit_w;
        end else begin
          res_q <= res_q >> 1;
        end
      end
      ajd_pkg::OP_TAP: begin
        acc_q <= ((cmd_i.cnt[2:0] == 3'd0) ? 32'd0 : acc_q) + 32'(tap_prod);
      end
      ajd_pkg::OP_FILT: filt_q <= rnd[30:11];
      ajd_pkg::OP_DET:  hit_q  <= hit_n;
      ajd_pkg::OP_OUT: begin
        odata_q <= {2'b00, filt_q, cap, hit_q, jt_q, locked_q};
      end
      default: ;
    endcase
    // window accumulation pipeline: read, square, add
    x_q    <= rd_q;
    prod_q <= rd_q * rd_q;
    if (cmd_i.op == ajd_pkg::OP_SUM) begin
      if (cmd_i.cnt == '0) begin
        sum_q <= '0;
        sq_q  <= '0;
      end else if (v2_q) begin
        sum_q <= sum_q + ajd_pkg::SUM_W'(x_q);
        sq_q  <= sq_q + ajd_pkg::SQ_W'(prod_q);
      end
    end
    if (cmd_i.op == ajd_pkg::OP_CHK1) sum2_q <= sum_q * sum_q;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ajd_pkg::FIR_TAPS - 1; i++) hist_q[i] <= '0;
      warm_q     <= '0;
      fill_q     <= '0;
      base_ptr_q <= '0;
      locked_q   <= 1'b0;
      baseline_q <= ajd_pkg::ONE_G_Q4;
      peak_q     <= {1'b0, ajd_pkg::ONE_G_Q4} + 21'd32768;
      prev_q     <= '0;
      rise_q     <= 1'b0;
      rearm_q    <= 1'b0;
      conf_q     <= 1'b0;
      run_q      <= '0;
      last_q     <= '0;
      jt_q       <= '0;
      v1_q       <= 1'b0;
      v2_q       <= 1'b0;
      ovalid_q   <= 1'b0;
    end else begin
      v1_q <= issue;
      v2_q <= v1_q;
      if (cmd_i.op == ajd_pkg::OP_OUT) begin
        ovalid_q <= 1'b1;
      end else if (ovalid_q && out_ready_i) begin
        ovalid_q <= 1'b0;
      end
      case (cmd_i.op)
        ajd_pkg::OP_ACT: begin
          if (icmd_q == ajd_pkg::CMD_CLEAR || icmd_q == ajd_pkg::CMD_RESTART) begin
            jt_q    <= '0;
            prev_q  <= '0;
            rise_q  <= 1'b0;
            rearm_q <= 1'b0;
            conf_q  <= 1'b0;
            run_q   <= '0;
            last_q  <= '0;
          end
          if (icmd_q == ajd_pkg::CMD_RESTART) begin
            for (int i = 0; i < ajd_pkg::FIR_TAPS - 1; i++) hist_q[i] <= '0;
            warm_q     <= '0;
            fill_q     <= '0;
            locked_q   <= 1'b0;
            baseline_q <= ajd_pkg::ONE_G_Q4;
            peak_q     <= {1'b0, ajd_pkg::ONE_G_Q4} + {1'b0, cfg_i.peak_thr};
          end
        end
        ajd_pkg::OP_FILT: begin
          for (int i = ajd_pkg::FIR_TAPS - 2; i > 0; i--) hist_q[i] <= hist_q[i-1];
          hist_q[0] <= res_q[15:0];
        end
        ajd_pkg::OP_CAL: begin
          if (warm_q < 8'(ajd_pkg::WARMUP_N)) begin
            warm_q <= warm_q + 8'd1;
          end else if (fill_q < (AW+1)'(ajd_pkg::WIN_N)) begin
            fill_q <= fill_q + 1'b1;
          end
        end
        ajd_pkg::OP_CHK2: begin
          if (win_ok) begin
            baseline_q <= sum_q[ajd_pkg::SUM_W-1:AW];
            peak_q     <= {1'b0, sum_q[ajd_pkg::SUM_W-1:AW]} + {1'b0, cfg_i.peak_thr};
            locked_q   <= 1'b1;
            prev_q     <= filt_q;
          end else begin
            base_ptr_q <= base_ptr_q + AW'(ajd_pkg::WIN_N / 2);
            fill_q     <= (AW+1)'(ajd_pkg::WIN_N - ajd_pkg::WIN_N / 2);
          end
        end
        ajd_pkg::OP_DET: begin
          run_q   <= run_n;
          conf_q  <= conf_n;
          rise_q  <= rise_n;
          rearm_q <= rearm_n;
          jt_q    <= jt_n;
          last_q  <= last_n;
          prev_q  <= filt_q;
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_lock_from_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(locked_q) |-> $past(cmd_i.op == ajd_pkg::OP_CHK2))
    else $error("baseline locked outside the window check");

  a_count_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(jt_q) |-> ($past(cmd_i.op == ajd_pkg::OP_DET) || $past(cmd_i.op == ajd_pkg::OP_ACT)))
    else $error("jump count changed without detect or command");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= (AW+1)'(ajd_pkg::WIN_N))
    else $error("window fill past depth");

  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ovalid_q) |-> $past(cmd_i.op == ajd_pkg::OP_OUT))
    else $error("result raised without an output step");
`endif

endmodule

// ===== sv/accel_jump_detector.sv =====
// sequencing: a command goes straight to the output step; a sample passes the square, root and
// filter steps, and when the calibration window fills it is swept over one read port and checked
// throughput: one item at a time, the next transfer is taken only once the last has reached the
// output step; the 16-step square root and 7-tap filter dominate a sample's processing, and a result
// waiting in the output register holds the next one back
// reset: asynchronous, active low; config to defaults, baseline one g, window empty
// ----------------------------------------------------------------------------
// accel_jump_detector
// accelerometer jump counter with baseline calibration and hall total cap
// ----------------------------------------------------------------------------
module accel_jump_detector (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config write port
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  // sample stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [95:0] s_axis_tdata,  // accel_x, accel_y, accel_z, now_ms, hall_total
  input  logic [1:0]  s_axis_tuser,  // cmd
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata   // ready_res, jump_count, jump_now, capped_total,
                                     // filtered_level, zero pad
);

  ajd_pkg::cfg_t     cfg_q;
  ajd_pkg::dp_cmd_t  dp_cmd;
  ajd_pkg::dp_stat_t dp_stat;

  // config registers, to be written only while idle; the block itself does not enforce it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.peak_thr  <= 20'd32768;
      cfg_q.reset_hys <= 20'd13107;
      cfg_q.dip_depth <= 20'd19661;
      cfg_q.dip_min   <= 8'd4;
      cfg_q.min_int   <= 16'd200;
      cfg_q.var_max   <= 32'd10738729;
      cfg_q.base_min  <= 20'd52429;
      cfg_q.base_max  <= 20'd78643;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ajd_pkg::REG_PEAK_THR:  cfg_q.peak_thr  <= cfg_wdata_i[19:0];
        ajd_pkg::REG_RESET_HYS: cfg_q.reset_hys <= cfg_wdata_i[19:0];
        ajd_pkg::REG_DIP_DEPTH: cfg_q.dip_depth <= cfg_wdata_i[19:0];
        ajd_pkg::REG_DIP_MIN:   cfg_q.dip_min   <= cfg_wdata_i[7:0];
        ajd_pkg::REG_MIN_INT:   cfg_q.min_int   <= cfg_wdata_i[15:0];
        ajd_pkg::REG_VAR_MAX:   cfg_q.var_max   <= cfg_wdata_i;
        ajd_pkg::REG_BASE_MIN:  cfg_q.base_min  <= cfg_wdata_i[19:0];
        ajd_pkg::REG_BASE_MAX:  cfg_q.base_max  <= cfg_wdata_i[19:0];
        default: ;
      endcase
    end
  end

  // sequencer: accepts a transfer only when idle
  ajd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_cmd_i   (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .stat_i     (dp_stat),
    .cmd_o      (dp_cmd)
  );

  // datapath with its own output register, so the next sample can start
  // while a result transfer is pending
  ajd_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (dp_cmd),
    .stat_o      (dp_stat),
    .cfg_i       (cfg_q),
    .in_cmd_i    (s_axis_tuser),
    .in_data_i   (s_axis_tdata),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule
